@@ hw/rtl/srp_pkg.sv @@
`default_nettype none
package srp_pkg;

  localparam int DataW = 8;
  localparam int TdataW = 232;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_IPV4 = 3'd1;
  localparam logic [2:0] PH_DLEN = 3'd2;
  localparam logic [2:0] PH_DNAME = 3'd3;
  localparam logic [2:0] PH_IPV6 = 3'd4;
  localparam logic [2:0] PH_PORT = 3'd5;

  localparam logic [7:0] AT_IPV4 = 8'h01;
  localparam logic [7:0] AT_DOMAIN = 8'h03;
  localparam logic [7:0] AT_IPV6 = 8'h04;
  localparam logic [7:0] IPV6_BYTES = 8'd16;

  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [3:0] KIND_VERSION = 4'd0;
  localparam logic [3:0] KIND_COMMAND = 4'd1;
  localparam logic [3:0] KIND_RESERVED = 4'd2;
  localparam logic [3:0] KIND_ATYPE = 4'd3;
  localparam logic [3:0] KIND_IPV4 = 4'd4;
  localparam logic [3:0] KIND_DLEN = 4'd5;
  localparam logic [3:0] KIND_DNAME = 4'd6;
  localparam logic [3:0] KIND_IPV6_HI = 4'd7;
  localparam logic [3:0] KIND_IPV6_LO = 4'd8;
  localparam logic [3:0] KIND_PORT = 4'd9;

  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] status;
    logic [DataW-1:0] data;
  } op_t;

endpackage
`default_nettype wire

@@ hw/rtl/socks5_request_parser.sv @@
`default_nettype none
// socks5 connect request parser: one request byte per transaction in, one result per byte
// out, with status (more, done, error) and all fields parsed so far; sustains one byte per
// cycle while results are taken; each byte passes through the two-entry queue register that
// takes the classified byte and the field registers that drive the result; the input stalls
// while the queue holds two bytes, which comes about only when a result is not taken
module socks5_request_parser (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // data_byte
  input  wire logic [7:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // status, version, command, reserved_byte, address_type, ipv4_address, ipv6_high,
  // ipv6_low, port_number, domain_length, domain_char, domain_char_valid, zero pad
  output logic [srp_pkg::TdataW-1:0] m_tdata
);

  srp_pkg::op_t front_op;
  srp_pkg::op_t q_op;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  srp_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_data(s_tdata),
    .q_full(q_full),
    .in_ready(s_tready),
    .push(push),
    .op(front_op)
  );

  srp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_op(front_op),
    .full(q_full),
    .pop(pop),
    .q_valid(q_valid),
    .q_op(q_op)
  );

  srp_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_op(q_op),
    .pop(pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire

@@ hw/rtl/srp_front.sv @@
`default_nettype none
module srp_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [srp_pkg::DataW-1:0] in_data,
  input  wire logic q_full,
  output logic in_ready,
  output logic push,
  output srp_pkg::op_t op
);

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic [2:0] ph;
  logic [7:0] bl;
  logic [7:0] bl_dec;

  assign in_ready = !q_full;
  assign push = in_valid && in_ready;
  assign bl_dec = bl - 8'd1;

  always_comb begin
    ph = (phase > srp_pkg::PH_PORT) ? srp_pkg::PH_HEADER : phase;
    bl = bytes_left;
    if (phase > srp_pkg::PH_PORT) begin
      bl = 8'd4;
    end else if (ph == srp_pkg::PH_HEADER) begin
      if (bytes_left == 8'd0 || bytes_left > 8'd4) begin
        bl = 8'd4;
      end
    end else if (bytes_left == 8'd0) begin
      bl = 8'd1;
    end
  end

  always_comb begin
    op.data = in_data;
    op.status = srp_pkg::ST_MORE;
    op.kind = srp_pkg::KIND_VERSION;
    phase_next = ph;
    bytes_left_next = bl_dec;
    unique case (ph)
      srp_pkg::PH_IPV4, srp_pkg::PH_DNAME, srp_pkg::PH_IPV6: begin
        if (ph == srp_pkg::PH_IPV4) begin
          op.kind = srp_pkg::KIND_IPV4;
        end else if (ph == srp_pkg::PH_DNAME) begin
          op.kind = srp_pkg::KIND_DNAME;
        end else if (bl > 8'd8) begin
          op.kind = srp_pkg::KIND_IPV6_HI;
        end else begin
          op.kind = srp_pkg::KIND_IPV6_LO;
        end
        if (bl_dec == 8'd0) begin
          phase_next = srp_pkg::PH_PORT;
          bytes_left_next = 8'd2;
        end
      end
      srp_pkg::PH_DLEN: begin
        op.kind = srp_pkg::KIND_DLEN;
        if (in_data == 8'd0) begin
          op.status = srp_pkg::ST_ERROR;
          phase_next = srp_pkg::PH_HEADER;
          bytes_left_next = 8'd4;
        end else begin
          phase_next = srp_pkg::PH_DNAME;
          bytes_left_next = in_data;
        end
      end
      srp_pkg::PH_PORT: begin
        op.kind = srp_pkg::KIND_PORT;
        if (bl_dec == 8'd0) begin
          op.status = srp_pkg::ST_DONE;
          phase_next = srp_pkg::PH_HEADER;
          bytes_left_next = 8'd4;
        end
      end
      default: begin
        priority if (bl == 8'd4) begin
          op.kind = srp_pkg::KIND_VERSION;
        end else if (bl == 8'd3) begin
          op.kind = srp_pkg::KIND_COMMAND;
        end else if (bl == 8'd2) begin
          op.kind = srp_pkg::KIND_RESERVED;
        end else begin
          op.kind = srp_pkg::KIND_ATYPE;
          priority if (in_data == srp_pkg::AT_IPV4) begin
            phase_next = srp_pkg::PH_IPV4;
            bytes_left_next = 8'd4;
          end else if (in_data == srp_pkg::AT_DOMAIN) begin
            phase_next = srp_pkg::PH_DLEN;
            bytes_left_next = 8'd1;
          end else if (in_data == srp_pkg::AT_IPV6) begin
            phase_next = srp_pkg::PH_IPV6;
            bytes_left_next = srp_pkg::IPV6_BYTES;
          end else begin
            op.status = srp_pkg::ST_DONE;
            phase_next = srp_pkg::PH_HEADER;
            bytes_left_next = 8'd4;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= srp_pkg::PH_HEADER;
      bytes_left <= 8'd4;
    end else if (push) begin
      phase <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/srp_queue.sv @@
`default_nettype none
module srp_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire srp_pkg::op_t push_op,
  output logic full,
  input  wire logic pop,
  output logic q_valid,
  output srp_pkg::op_t q_op
);

  srp_pkg::op_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("push into full queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/srp_back.sv @@
`default_nettype none
module srp_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire srp_pkg::op_t q_op,
  output logic pop,
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [srp_pkg::TdataW-1:0] m_tdata
);

  logic [1:0] status;
  logic [7:0] version;
  logic [7:0] command;
  logic [7:0] reserved_byte;
  logic [7:0] address_type;
  logic [31:0] ipv4_address;
  logic [63:0] ipv6_high;
  logic [63:0] ipv6_low;
  logic [15:0] port_number;
  logic [7:0] domain_length;
  logic [7:0] domain_char;
  logic domain_char_valid;

  assign pop = q_valid && (!m_tvalid || m_tready);

  assign m_tdata = {5'd0, domain_char_valid, domain_char, domain_length, port_number,
                    ipv6_low, ipv6_high, ipv4_address, address_type, reserved_byte,
                    command, version, status};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= srp_pkg::ST_MORE;
      version <= 8'd0;
      command <= 8'd0;
      reserved_byte <= 8'd0;
      address_type <= 8'd0;
      ipv4_address <= 32'd0;
      ipv6_high <= 64'd0;
      ipv6_low <= 64'd0;
      port_number <= 16'd0;
      domain_length <= 8'd0;
      domain_char <= 8'd0;
      domain_char_valid <= 1'b0;
    end else if (pop) begin
      status <= q_op.status;
      domain_char <= 8'd0;
      domain_char_valid <= 1'b0;
      unique case (q_op.kind)
        srp_pkg::KIND_VERSION: begin
          version <= q_op.data;
          command <= 8'd0;
          reserved_byte <= 8'd0;
          address_type <= 8'd0;
          ipv4_address <= 32'd0;
          ipv6_high <= 64'd0;
          ipv6_low <= 64'd0;
          port_number <= 16'd0;
          domain_length <= 8'd0;
        end
        srp_pkg::KIND_COMMAND: command <= q_op.data;
        srp_pkg::KIND_RESERVED: reserved_byte <= q_op.data;
        srp_pkg::KIND_ATYPE: address_type <= q_op.data;
        srp_pkg::KIND_IPV4: ipv4_address <= {ipv4_address[23:0], q_op.data};
        srp_pkg::KIND_DLEN: domain_length <= q_op.data;
        srp_pkg::KIND_DNAME: begin
          domain_char <= q_op.data;
          domain_char_valid <= 1'b1;
        end
        srp_pkg::KIND_IPV6_HI: ipv6_high <= {ipv6_high[55:0], q_op.data};
        srp_pkg::KIND_IPV6_LO: ipv6_low <= {ipv6_low[55:0], q_op.data};
        srp_pkg::KIND_PORT: port_number <= {port_number[7:0], q_op.data};
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_dchar_more: assert property (@(posedge clk) disable iff (rst)
    domain_char_valid |-> status == srp_pkg::ST_MORE)
    else $error("domain byte with final status");
  a_error_len: assert property (@(posedge clk) disable iff (rst)
    status == srp_pkg::ST_ERROR |-> domain_length == 8'd0)
    else $error("error with nonzero domain length");
  a_new_request: assert property (@(posedge clk) disable iff (rst)
    pop && q_op.kind == srp_pkg::KIND_VERSION |=> command == 8'd0 && port_number == 16'd0)
    else $error("fields not cleared on new request");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;

  localparam int CycleLimit = 200000;
  localparam int ByteTarget = 650;

  // result layout of m_tdata, lowest field last
  typedef struct packed {
    logic [4:0] pad;
    logic dvalid;
    logic [7:0] dchar;
    logic [7:0] dlen;
    logic [15:0] port;
    logic [63:0] ipv6_lo;
    logic [63:0] ipv6_hi;
    logic [31:0] ipv4;
    logic [7:0] atype;
    logic [7:0] rsvd;
    logic [7:0] cmd;
    logic [7:0] version;
    logic [1:0] status;
  } fields_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [srp_pkg::TdataW-1:0] m_tdata;

  socks5_request_parser dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  // parser state as the block should hold it
  logic [2:0] phase_now;
  logic [7:0] left_now;
  fields_t parsed;

  fields_t fields_due[$];
  logic [7:0] msg[$];
  fields_t want;
  fields_t got;
  int mismatches = 0;
  int bytes_sent = 0;
  int cycles = 0;
  int hold_len = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  function automatic fields_t parse_byte(input logic [7:0] b);
    fields_t r;
    logic [1:0] st;
    logic [7:0] dc;
    logic dv;
    st = srp_pkg::ST_MORE;
    dc = 8'h00;
    dv = 1'b0;
    if (phase_now > srp_pkg::PH_PORT) begin
      phase_now = srp_pkg::PH_HEADER;
      left_now = 8'd4;
    end
    if (phase_now != srp_pkg::PH_HEADER && left_now == 8'd0) left_now = 8'd1;
    case (phase_now)
      srp_pkg::PH_IPV4: begin
        parsed.ipv4 = {parsed.ipv4[23:0], b};
        left_now = left_now - 8'd1;
        if (left_now == 8'd0) begin
          phase_now = srp_pkg::PH_PORT;
          left_now = 8'd2;
        end
      end
      srp_pkg::PH_DLEN: begin
        parsed.dlen = b;
        if (b == 8'd0) begin
          st = srp_pkg::ST_ERROR;
          phase_now = srp_pkg::PH_HEADER;
          left_now = 8'd4;
        end else begin
          phase_now = srp_pkg::PH_DNAME;
          left_now = b;
        end
      end
      srp_pkg::PH_DNAME: begin
        dc = b;
        dv = 1'b1;
        left_now = left_now - 8'd1;
        if (left_now == 8'd0) begin
          phase_now = srp_pkg::PH_PORT;
          left_now = 8'd2;
        end
      end
      srp_pkg::PH_IPV6: begin
        if (left_now > 8'd8) parsed.ipv6_hi = {parsed.ipv6_hi[55:0], b};
        else parsed.ipv6_lo = {parsed.ipv6_lo[55:0], b};
        left_now = left_now - 8'd1;
        if (left_now == 8'd0) begin
          phase_now = srp_pkg::PH_PORT;
          left_now = 8'd2;
        end
      end
      srp_pkg::PH_PORT: begin
        parsed.port = {parsed.port[7:0], b};
        left_now = left_now - 8'd1;
        if (left_now == 8'd0) begin
          st = srp_pkg::ST_DONE;
          phase_now = srp_pkg::PH_HEADER;
          left_now = 8'd4;
        end
      end
      default: begin
        if (left_now == 8'd0 || left_now > 8'd4) left_now = 8'd4;
        if (left_now == 8'd4) begin
          parsed = '0;
          parsed.version = b;
          left_now = 8'd3;
        end else if (left_now == 8'd3) begin
          parsed.cmd = b;
          left_now = 8'd2;
        end else if (left_now == 8'd2) begin
          parsed.rsvd = b;
          left_now = 8'd1;
        end else begin
          parsed.atype = b;
          if (b == srp_pkg::AT_IPV4) begin
            phase_now = srp_pkg::PH_IPV4;
            left_now = 8'd4;
          end else if (b == srp_pkg::AT_DOMAIN) begin
            phase_now = srp_pkg::PH_DLEN;
            left_now = 8'd1;
          end else if (b == srp_pkg::AT_IPV6) begin
            phase_now = srp_pkg::PH_IPV6;
            left_now = srp_pkg::IPV6_BYTES;
          end else begin
            st = srp_pkg::ST_DONE;
            phase_now = srp_pkg::PH_HEADER;
            left_now = 8'd4;
          end
        end
      end
    endcase
    r = parsed;
    r.pad = '0;
    r.status = st;
    r.dchar = dc;
    r.dvalid = dv;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    fields_due.push_back(parse_byte(b));
    bytes_sent++;
  endtask

  task automatic idle_sender();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (fields_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_byte(msg[i]);
    msg.delete();
  endtask

  task automatic add_request(input logic [7:0] at, input int dl);
    repeat (3) msg.push_back(8'($urandom));
    msg.push_back(at);
    case (at)
      srp_pkg::AT_IPV4: repeat (4) msg.push_back(8'($urandom));
      srp_pkg::AT_DOMAIN: begin
        msg.push_back(8'(dl));
        repeat (dl) msg.push_back(8'($urandom));
      end
      srp_pkg::AT_IPV6: repeat (16) msg.push_back(8'($urandom));
      default: ;
    endcase
    if (at == srp_pkg::AT_IPV4 || at == srp_pkg::AT_IPV6 ||
        (at == srp_pkg::AT_DOMAIN && dl != 0))
      repeat (2) msg.push_back(8'($urandom));
  endtask

  task automatic test_unknown_type();
    msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    send_msg();
  endtask

  task automatic test_zero_domain();
    msg = '{8'h05, 8'h01, 8'h00, srp_pkg::AT_DOMAIN, 8'h00};
    send_msg();
  endtask

  task automatic test_ipv4();
    msg = '{8'h05, 8'h01, 8'h00, srp_pkg::AT_IPV4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_msg();
  endtask

  task automatic test_domain();
    msg = '{8'h05, 8'h01, 8'h00, srp_pkg::AT_DOMAIN, 8'h01, 8'h61, 8'h00, 8'h00};
    send_msg();
  endtask

  task automatic test_ipv6();
    msg = '{8'h05, 8'h01, 8'h00, srp_pkg::AT_IPV6};
    for (int i = 0; i < 16; i++) msg.push_back(8'(8'h80 | i * 17));
    msg.push_back(8'h12);
    msg.push_back(8'h34);
    send_msg();
  endtask

  task automatic test_random_requests();
    int pick;
    int dl;
    logic [7:0] at;
    while (bytes_sent < ByteTarget) begin
      pick = $urandom_range(0, 99);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (pick < 80) begin
        case ($urandom_range(0, 2))
          0: at = srp_pkg::AT_IPV4;
          1: at = srp_pkg::AT_DOMAIN;
          default: at = srp_pkg::AT_IPV6;
        endcase
        dl = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
        add_request(at, dl);
      end else if (pick < 87) begin
        do at = 8'($urandom);
        while (at == srp_pkg::AT_IPV4 || at == srp_pkg::AT_DOMAIN || at == srp_pkg::AT_IPV6);
        add_request(at, 0);
      end else if (pick < 93) begin
        add_request(srp_pkg::AT_DOMAIN, 0);
      end else begin
        repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
      end
      send_msg();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    tx_steady = 1'b1;
    hold_len = 80;
    add_request(srp_pkg::AT_IPV6, 0);
    add_request(srp_pkg::AT_DOMAIN, 255);
    add_request(srp_pkg::AT_IPV4, 0);
    send_msg();
    tx_steady = 1'b0;
    idle_sender();
    wait_drained();
  endtask

  task automatic test_paused_sender();
    add_request(srp_pkg::AT_IPV6, 0);
    foreach (msg[i]) begin
      if (i == 10) begin
        idle_sender();
        wait_drained();
      end
      send_byte(msg[i]);
    end
    msg.delete();
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (fields_due.size() == 0) begin
        $error("result transaction with no byte outstanding");
        mismatches++;
      end else begin
        want = fields_due.pop_front();
        got = fields_t'(m_tdata);
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("version", 64'(want.version), 64'(got.version));
        check_field("command", 64'(want.cmd), 64'(got.cmd));
        check_field("reserved_byte", 64'(want.rsvd), 64'(got.rsvd));
        check_field("address_type", 64'(want.atype), 64'(got.atype));
        check_field("ipv4_address", 64'(want.ipv4), 64'(got.ipv4));
        check_field("ipv6_high", want.ipv6_hi, got.ipv6_hi);
        check_field("ipv6_low", want.ipv6_lo, got.ipv6_lo);
        check_field("port_number", 64'(want.port), 64'(got.port));
        check_field("domain_length", 64'(want.dlen), 64'(got.dlen));
        check_field("domain_char", 64'(want.dchar), 64'(got.dchar));
        check_field("domain_char_valid", 64'(want.dvalid), 64'(got.dvalid));
        check_field("zero pad", 64'(want.pad), 64'(got.pad));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    int gap;
    int n;
    wait (!rst);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        repeat (n) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready) && hold_len == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    phase_now = srp_pkg::PH_HEADER;
    left_now = 8'd4;
    parsed = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unknown_type();
    test_zero_domain();
    test_ipv4();
    test_domain();
    test_ipv6();
    test_backpressure();
    test_paused_sender();
    test_random_requests();
    idle_sender();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
